// ----- hw/rtl/bpf_pkg.sv -----
// shared types and constants for the befunge playfield core
// no dependencies
package bpf_pkg;

	localparam int MAX_COLS    = 128;
	localparam int MAX_ROWS    = 32;
	localparam int STACK_DEPTH = 1024;
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int PF_AW       = COL_W + ROW_W;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int CNT_W       = SP_W + 1;

	localparam logic [1:0] ACT_LOAD    = 2'd0;
	localparam logic [1:0] ACT_STEP    = 2'd1;
	localparam logic [1:0] ACT_RESTART = 2'd2;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_CHAR = 2'd1;
	localparam logic [1:0] KIND_NUM  = 2'd2;

	localparam logic [1:0] STAT_RUN = 2'd0;
	localparam logic [1:0] STAT_END = 2'd1;
	localparam logic [1:0] STAT_PUT = 2'd2;
	localparam logic [1:0] STAT_OVF = 2'd3;

	localparam logic [1:0] HD_RIGHT = 2'd0;
	localparam logic [1:0] HD_DOWN  = 2'd1;
	localparam logic [1:0] HD_LEFT  = 2'd2;
	localparam logic [1:0] HD_UP    = 2'd3;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	localparam logic [31:0] OP_ADD    = 32'h2B;
	localparam logic [31:0] OP_SUB    = 32'h2D;
	localparam logic [31:0] OP_MUL    = 32'h2A;
	localparam logic [31:0] OP_DIV    = 32'h2F;
	localparam logic [31:0] OP_MOD    = 32'h25;
	localparam logic [31:0] OP_NOT    = 32'h21;
	localparam logic [31:0] OP_GT     = 32'h60;
	localparam logic [31:0] OP_COMMA  = 32'h2C;
	localparam logic [31:0] OP_DOT    = 32'h2E;
	localparam logic [31:0] OP_END    = 32'h40;
	localparam logic [31:0] OP_RIGHT  = 32'h3E;
	localparam logic [31:0] OP_DOWN   = 32'h76;
	localparam logic [31:0] OP_LEFT   = 32'h3C;
	localparam logic [31:0] OP_UP     = 32'h5E;
	localparam logic [31:0] OP_RAND   = 32'h3F;
	localparam logic [31:0] OP_HBR    = 32'h5F;
	localparam logic [31:0] OP_VBR    = 32'h7C;
	localparam logic [31:0] OP_BRIDGE = 32'h23;
	localparam logic [31:0] OP_DUP    = 32'h3A;
	localparam logic [31:0] OP_SWAP   = 32'h5C;
	localparam logic [31:0] OP_DROP   = 32'h24;
	localparam logic [31:0] OP_GET    = 32'h67;
	localparam logic [31:0] OP_PUT    = 32'h70;
	localparam logic [31:0] OP_INNUM  = 32'h26;
	localparam logic [31:0] OP_INCHR  = 32'h7E;
	localparam logic [31:0] OP_QUOTE  = 32'h22;
	localparam logic [31:0] DIGIT_LO  = 32'h30;
	localparam logic [31:0] DIGIT_HI  = 32'h39;

	typedef struct packed {
		logic [1:0]         action;
		logic [6:0]         cell_col;
		logic [4:0]         cell_row;
		logic signed [31:0] cell_value;
		logic [1:0]         random_dir;
		logic [7:0]         input_char;
	} item_t;

	typedef struct packed {
		logic [1:0]         out_kind;
		logic signed [31:0] out_value;
		logic [1:0]         status;
		logic               used_input;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NORM,
		ST_FETCH,
		ST_DECODE,
		ST_POP,
		ST_POPW,
		ST_EXEC,
		ST_DIV,
		ST_DIVFIX,
		ST_GWAIT,
		ST_PUSH,
		ST_ADV,
		ST_FIN
	} state_t;

endpackage

// ----- hw/rtl/bpf_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module bpf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/befunge_playfield_core.sv -----
// path from input transfer to result: load, restart or a step while halted go straight to the result;
// a step folds the counter, fetches, decodes, pops, executes, pushes and advances (string mode skips
// pop and execute), with a divider pass for divide or modulo and a playfield read for get
// throughput: one item at a time, next transfer at the earliest as the result appears;
// reset: arst_n clears control state; playfield and stack rams are not cleared
// top level of the befunge playfield core, uses bpf_pkg and bpf_ram
module befunge_playfield_core
	import bpf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;

	logic [7:0]       width_q;
	logic [5:0]       height_q;
	logic [7:0]       w_act;
	logic [5:0]       h_act;
	item_t            in_q;
	logic [COL_W-1:0] pc_col_q;
	logic [ROW_W-1:0] pc_row_q;
	logic [1:0]       heading_q;
	logic             strmode_q;
	logic [1:0]       status_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      cur_q, a1_q, a2_q, a3_q, pv0_q, pv1_q;
	logic [1:0]       npop_q, popi_q, npush_q;
	logic             skip_q;
	logic [1:0]       kind_q;
	logic [31:0]      oval_q;
	logic             used_q;
	result_t          result_q;
	logic             result_valid_q;
	logic [31:0]      rem_q;
	logic [31:0]      quo_q;
	logic [5:0]       dcnt_q;

	logic             pf_we, st_we;
	logic [PF_AW-1:0] pf_waddr, pf_raddr;
	logic [31:0]      pf_wdata, pf_rdata, st_wdata, st_rdata;
	logic [SP_W-1:0]  st_waddr, st_raddr;

	logic             col_out, row_out, in_grid, xy_ok, stk_full, is_digit;
	logic [COL_W-1:0] col_adv;
	logic [ROW_W-1:0] row_adv;
	logic [31:0]      prod;
	logic [31:0]      dvs_mag, dvd_mag, q_fix, r_fix;
	logic [32:0]      rem_sh, rem_diff;
	logic             take;
	logic [7:0]       dig_byte;
	logic             item_acc, cfg_wr;

	function automatic logic [1:0] pop_count(input logic [31:0] op);
		logic [1:0] n;
		n = 2'd0;
		case (op) inside
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_GT, OP_SWAP, OP_GET: n = 2'd2;
			OP_PUT: n = 2'd3;
			OP_NOT, OP_COMMA, OP_DOT, OP_HBR, OP_VBR, OP_DUP, OP_DROP: n = 2'd1;
			default: n = 2'd0;
		endcase
		return n;
	endfunction

	function automatic logic [31:0] sext8(input logic [7:0] b);
		return {{24{b[7]}}, b};
	endfunction

	assign item_acc = item_valid && item_ready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_HEIGHT) ? {26'd0, height_q} : {24'd0, width_q};

	assign w_act = (width_q == 8'd0) ? 8'd1 :
		(width_q > 8'(MAX_COLS)) ? 8'(MAX_COLS) : width_q;
	assign h_act = (height_q == 6'd0) ? 6'd1 :
		(height_q > 6'(MAX_ROWS)) ? 6'(MAX_ROWS) : height_q;

	assign col_out  = {1'b0, pc_col_q} >= w_act;
	assign row_out  = {1'b0, pc_row_q} >= h_act;
	assign in_grid  = !col_out && !row_out;
	assign xy_ok    = (a1_q < 32'(h_act)) && (a2_q < 32'(w_act));
	assign stk_full = count_q >= CNT_W'(STACK_DEPTH);
	assign is_digit = (cur_q >= DIGIT_LO) && (cur_q <= DIGIT_HI);
	assign prod     = a2_q * a1_q;
	assign dig_byte = in_q.input_char - DIGIT_LO[7:0];

	// one step of the counter along the heading, counter already inside the grid
	always_comb begin
		col_adv = pc_col_q;
		row_adv = pc_row_q;
		unique case (heading_q)
			HD_RIGHT: col_adv = ({1'b0, pc_col_q} + 8'd1 == w_act) ? '0 : pc_col_q + 1'b1;
			HD_DOWN:  row_adv = ({1'b0, pc_row_q} + 6'd1 == h_act) ? '0 : pc_row_q + 1'b1;
			HD_LEFT:  col_adv = (pc_col_q == '0) ? COL_W'(w_act - 8'd1) : pc_col_q - 1'b1;
			HD_UP:    row_adv = (pc_row_q == '0) ? ROW_W'(h_act - 6'd1) : pc_row_q - 1'b1;
			default:  col_adv = pc_col_q;
		endcase
	end

	// restoring divider on magnitudes
	assign dvs_mag  = a1_q[31] ? 32'(-a1_q) : a1_q;
	assign dvd_mag  = a2_q[31] ? 32'(-a2_q) : a2_q;
	assign rem_sh   = {rem_q, quo_q[31]};
	assign rem_diff = rem_sh - {1'b0, dvs_mag};
	assign take     = !rem_diff[32];
	assign q_fix    = (a1_q[31] ^ a2_q[31]) ? 32'(-quo_q) : quo_q;
	assign r_fix    = a2_q[31] ? 32'(-rem_q) : rem_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_acc) begin
					if (item.action == ACT_STEP && status_q == STAT_RUN) state_d = ST_NORM;
					else state_d = ST_FIN;
				end
			end
			ST_NORM:   if (in_grid) state_d = ST_FETCH;
			ST_FETCH:  state_d = ST_DECODE;
			ST_DECODE: begin
				if (strmode_q) state_d = (cur_q == OP_QUOTE) ? ST_ADV : ST_PUSH;
				else state_d = ST_POP;
			end
			ST_POP: begin
				if (popi_q == npop_q) state_d = ST_EXEC;
				else if (count_q != '0) state_d = ST_POPW;
			end
			ST_POPW: state_d = ST_POP;
			ST_EXEC: begin
				case (cur_q) inside
					OP_ADD, OP_SUB, OP_MUL, OP_GT, OP_NOT, OP_DUP, OP_SWAP,
					OP_INNUM, OP_INCHR: state_d = ST_PUSH;
					OP_DIV, OP_MOD: state_d = (a1_q == '0) ? ST_PUSH : ST_DIV;
					OP_END: state_d = ST_FIN;
					OP_GET: state_d = xy_ok ? ST_GWAIT : ST_PUSH;
					OP_PUT: state_d = xy_ok ? ST_ADV : ST_FIN;
					default: state_d = is_digit ? ST_PUSH : ST_ADV;
				endcase
			end
			ST_DIV:    if (dcnt_q == 6'd1) state_d = ST_DIVFIX;
			ST_DIVFIX: state_d = ST_PUSH;
			ST_GWAIT:  state_d = ST_PUSH;
			ST_PUSH: begin
				if (npush_q == 2'd0) state_d = ST_ADV;
				else if (stk_full) state_d = ST_FIN;
			end
			ST_ADV: if (!skip_q) state_d = ST_FIN;
			ST_FIN: if (!result_valid_q || result_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake and ram controls
	always_comb begin
		item_ready = (state_q == ST_IDLE);
		pf_we      = 1'b0;
		pf_waddr   = {item.cell_row, item.cell_col};
		pf_wdata   = item.cell_value;
		pf_raddr   = {pc_row_q, pc_col_q};
		st_we      = 1'b0;
		st_waddr   = count_q[SP_W-1:0];
		st_wdata   = pv0_q;
		st_raddr   = SP_W'(count_q - 1'b1);
		unique case (state_q)
			ST_IDLE: pf_we = item_acc && (item.action == ACT_LOAD);
			ST_EXEC: begin
				if (cur_q == OP_GET) pf_raddr = {a1_q[ROW_W-1:0], a2_q[COL_W-1:0]};
				if (cur_q == OP_PUT && xy_ok) begin
					pf_we    = 1'b1;
					pf_waddr = {a1_q[ROW_W-1:0], a2_q[COL_W-1:0]};
					pf_wdata = a3_q;
				end
			end
			ST_PUSH: st_we = (npush_q != 2'd0) && !stk_full;
			default: pf_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			width_q        <= 8'd80;
			height_q       <= 6'd25;
			pc_col_q       <= '0;
			pc_row_q       <= '0;
			heading_q      <= HD_RIGHT;
			strmode_q      <= 1'b0;
			status_q       <= STAT_RUN;
			count_q        <= '0;
			npop_q         <= '0;
			popi_q         <= '0;
			npush_q        <= '0;
			skip_q         <= 1'b0;
			dcnt_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				if (paddr[2] == REG_WIDTH) width_q <= pwdata[7:0];
				else height_q <= pwdata[5:0];
			end
			if (state_q == ST_FIN && (!result_valid_q || result_ready)) result_valid_q <= 1'b1;
			else if (result_valid_q && result_ready) result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (item_acc) begin
						in_q   <= item;
						kind_q <= KIND_NONE;
						oval_q <= '0;
						used_q <= 1'b0;
						skip_q <= 1'b0;
						if (item.action == ACT_RESTART) begin
							count_q   <= '0;
							pc_col_q  <= '0;
							pc_row_q  <= '0;
							heading_q <= HD_RIGHT;
							strmode_q <= 1'b0;
							status_q  <= STAT_RUN;
						end
					end
				end
				ST_NORM: begin
					// fold the counter back after the grid was made smaller
					if (col_out) pc_col_q <= pc_col_q - w_act[COL_W-1:0];
					if (row_out) pc_row_q <= pc_row_q - h_act[ROW_W-1:0];
				end
				ST_FETCH: cur_q <= pf_rdata;
				ST_DECODE: begin
					if (strmode_q) begin
						if (cur_q == OP_QUOTE) strmode_q <= 1'b0;
						pv0_q   <= cur_q;
						npush_q <= 2'd1;
					end
					npop_q <= pop_count(cur_q);
					popi_q <= '0;
				end
				ST_POP: begin
					if (popi_q != npop_q) begin
						if (count_q == '0) begin
							// empty stack pops zero
							case (popi_q)
								2'd0: a1_q <= '0;
								2'd1: a2_q <= '0;
								default: a3_q <= '0;
							endcase
							popi_q <= popi_q + 1'b1;
						end else begin
							count_q <= count_q - 1'b1;
						end
					end
				end
				ST_POPW: begin
					case (popi_q)
						2'd0: a1_q <= st_rdata;
						2'd1: a2_q <= st_rdata;
						default: a3_q <= st_rdata;
					endcase
					popi_q <= popi_q + 1'b1;
				end
				ST_EXEC: begin
					npush_q <= (cur_q == OP_DUP || cur_q == OP_SWAP) ? 2'd2 : 2'd1;
					case (cur_q) inside
						OP_ADD:   pv0_q <= a2_q + a1_q;
						OP_SUB:   pv0_q <= a2_q - a1_q;
						OP_MUL:   pv0_q <= prod;
						OP_GT:    pv0_q <= {31'd0, $signed(a2_q) > $signed(a1_q)};
						OP_NOT:   pv0_q <= {31'd0, a1_q == '0};
						OP_DIV, OP_MOD: begin
							pv0_q  <= '0;
							rem_q  <= '0;
							quo_q  <= dvd_mag;
							dcnt_q <= 6'd32;
						end
						OP_COMMA: begin
							kind_q <= KIND_CHAR;
							oval_q <= a1_q;
						end
						OP_DOT: begin
							kind_q <= KIND_NUM;
							oval_q <= a1_q;
						end
						OP_END:    status_q  <= STAT_END;
						OP_RIGHT:  heading_q <= HD_RIGHT;
						OP_DOWN:   heading_q <= HD_DOWN;
						OP_LEFT:   heading_q <= HD_LEFT;
						OP_UP:     heading_q <= HD_UP;
						OP_RAND:   heading_q <= in_q.random_dir;
						OP_HBR:    heading_q <= (a1_q == '0) ? HD_RIGHT : HD_LEFT;
						OP_VBR:    heading_q <= (a1_q == '0) ? HD_DOWN : HD_UP;
						OP_BRIDGE: skip_q    <= 1'b1;
						OP_DUP: begin
							pv0_q <= a1_q;
							pv1_q <= a1_q;
						end
						OP_SWAP: begin
							pv0_q <= a1_q;
							pv1_q <= a2_q;
						end
						OP_GET:   pv0_q <= '0;
						OP_PUT:   if (!xy_ok) status_q <= STAT_PUT;
						OP_INNUM: begin
							used_q <= 1'b1;
							pv0_q  <= sext8(dig_byte);
						end
						OP_INCHR: begin
							used_q <= 1'b1;
							pv0_q  <= sext8(in_q.input_char);
						end
						OP_QUOTE: strmode_q <= 1'b1;
						default:  pv0_q <= cur_q - DIGIT_LO;
					endcase
				end
				ST_DIV: begin
					rem_q  <= take ? rem_diff[31:0] : rem_sh[31:0];
					quo_q  <= {quo_q[30:0], take};
					dcnt_q <= dcnt_q - 1'b1;
				end
				ST_DIVFIX: pv0_q <= (cur_q == OP_DIV) ? q_fix : r_fix;
				ST_GWAIT:  pv0_q <= pf_rdata;
				ST_PUSH: begin
					if (npush_q != 2'd0) begin
						if (stk_full) begin
							status_q <= STAT_OVF;
						end else begin
							count_q <= count_q + 1'b1;
							pv0_q   <= pv1_q;
							npush_q <= npush_q - 1'b1;
						end
					end
				end
				ST_ADV: begin
					pc_col_q <= col_adv;
					pc_row_q <= row_adv;
					skip_q   <= 1'b0;
				end
				ST_FIN: begin
					if (!result_valid_q || result_ready) begin
						result_q.out_kind   <= kind_q;
						result_q.out_value  <= oval_q;
						result_q.status     <= status_q;
						result_q.used_input <= used_q;
					end
				end
				default: skip_q <= skip_q;
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	bpf_ram #(.WIDTH(32), .DEPTH(MAX_COLS * MAX_ROWS)) u_playfield (
		.clk   (clk),
		.we    (pf_we),
		.waddr (pf_waddr),
		.wdata (pf_wdata),
		.raddr (pf_raddr),
		.rdata (pf_rdata)
	);

	bpf_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");
	a_fetch_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |-> ({1'b0, pc_col_q} < w_act && {1'b0, pc_row_q} < h_act))
		else $error("cell fetched outside the active grid");
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (a1_q != '0))
		else $error("divider running on zero divisor");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		st_we |-> (count_q < CNT_W'(STACK_DEPTH)))
		else $error("stack write into a full stack");
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> !item_ready)
		else $error("second transfer taken while an item is at work");
`endif

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for befunge_playfield_core: directed table, a stack overflow run, then random programs
// depends on bpf_pkg and the core rtl; holds its own playfield interpreter as predictor
`timescale 1ns / 100ps

module tb;
	import bpf_pkg::*;

	typedef struct {
		item_t   it;
		bit      chk;
		result_t res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	befunge_playfield_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// interpreter copy of the machine
	logic [31:0] cells [MAX_ROWS*MAX_COLS];
	bit          cell_set [MAX_ROWS*MAX_COLS];
	logic [31:0] vstack [STACK_DEPTH];
	int unsigned vdepth = 0;
	int unsigned pcc = 0, pcr = 0;
	logic [1:0]  hdg = HD_RIGHT;
	bit          str_mode = 0;
	logic [1:0]  run_st = STAT_RUN;
	logic [7:0]  gw = 8'd80;
	logic [5:0]  gh = 6'd25;
	bit          ovf;

	result_t     pending_q [$];
	int          errs = 0;
	bit          calm = 0;
	int          stall = 0;

	function automatic int unsigned act_w();
		if (gw == 0) return 1;
		return (gw > MAX_COLS) ? MAX_COLS : gw;
	endfunction

	function automatic int unsigned act_h();
		if (gh == 0) return 1;
		return (gh > MAX_ROWS) ? MAX_ROWS : gh;
	endfunction

	function automatic logic [31:0] pop_v();
		if (vdepth == 0) return 32'd0;
		vdepth--;
		return vstack[vdepth];
	endfunction

	function automatic void push_v(logic [31:0] v);
		if (vdepth >= STACK_DEPTH) begin
			ovf = 1;
			return;
		end
		vstack[vdepth] = v;
		vdepth++;
	endfunction

	function automatic void move_pc(int unsigned w, int unsigned h);
		case (hdg)
			HD_RIGHT: pcc = (pcc + 1) % w;
			HD_DOWN:  pcr = (pcr + 1) % h;
			HD_LEFT:  pcc = (pcc + w - 1) % w;
			default:  pcr = (pcr + h - 1) % h;
		endcase
	endfunction

	function automatic void run_cell(item_t it, ref result_t r);
		int unsigned w, h;
		logic [31:0] cur, a1, a2, a3;
		longint      s1, s2;
		logic [7:0]  b;
		w = act_w();
		h = act_h();
		pcc = pcc % w;
		pcr = pcr % h;
		cur = cells[pcr*MAX_COLS + pcc];
		ovf = 0;
		if (str_mode) begin
			if (cur == OP_QUOTE) str_mode = 0;
			else push_v(cur);
			if (ovf) begin
				run_st = STAT_OVF;
				return;
			end
			move_pc(w, h);
			return;
		end
		case (cur)
			OP_ADD: begin a1 = pop_v(); a2 = pop_v(); push_v(a2 + a1); end
			OP_SUB: begin a1 = pop_v(); a2 = pop_v(); push_v(a2 - a1); end
			OP_MUL: begin a1 = pop_v(); a2 = pop_v(); push_v(a2 * a1); end
			OP_DIV, OP_MOD: begin
				a1 = pop_v(); a2 = pop_v();
				s1 = longint'($signed(a1));
				s2 = longint'($signed(a2));
				if (s1 == 0) push_v(32'd0);
				else if (cur == OP_DIV) push_v(32'(s2 / s1));
				else push_v(32'(s2 % s1));
			end
			OP_NOT: begin a1 = pop_v(); push_v((a1 == 0) ? 32'd1 : 32'd0); end
			OP_GT: begin
				a1 = pop_v(); a2 = pop_v();
				push_v(($signed(a2) > $signed(a1)) ? 32'd1 : 32'd0);
			end
			OP_COMMA: begin r.out_kind = KIND_CHAR; r.out_value = pop_v(); end
			OP_DOT: begin r.out_kind = KIND_NUM; r.out_value = pop_v(); end
			OP_END: begin run_st = STAT_END; return; end
			OP_RIGHT: hdg = HD_RIGHT;
			OP_DOWN:  hdg = HD_DOWN;
			OP_LEFT:  hdg = HD_LEFT;
			OP_UP:    hdg = HD_UP;
			OP_RAND:  hdg = it.random_dir;
			OP_HBR:   hdg = (pop_v() == 0) ? HD_RIGHT : HD_LEFT;
			OP_VBR:   hdg = (pop_v() == 0) ? HD_DOWN : HD_UP;
			OP_BRIDGE: move_pc(w, h);
			OP_DUP: begin a1 = pop_v(); push_v(a1); push_v(a1); end
			OP_SWAP: begin a1 = pop_v(); a2 = pop_v(); push_v(a1); push_v(a2); end
			OP_DROP: a1 = pop_v();
			OP_GET: begin
				a1 = pop_v(); a2 = pop_v();
				if (a1 < h && a2 < w) push_v(cells[a1*MAX_COLS + a2]);
				else push_v(32'd0);
			end
			OP_PUT: begin
				a1 = pop_v(); a2 = pop_v(); a3 = pop_v();
				if (a1 < h && a2 < w) begin
					cells[a1*MAX_COLS + a2] = a3;
					cell_set[a1*MAX_COLS + a2] = 1;
				end else begin
					run_st = STAT_PUT;
					return;
				end
			end
			OP_INNUM: begin
				r.used_input = 1'b1;
				b = it.input_char - 8'h30;
				push_v({{24{b[7]}}, b});
			end
			OP_INCHR: begin
				r.used_input = 1'b1;
				b = it.input_char;
				push_v({{24{b[7]}}, b});
			end
			OP_QUOTE: str_mode = 1;
			default: if (cur >= DIGIT_LO && cur <= DIGIT_HI) push_v(cur - DIGIT_LO);
		endcase
		if (ovf) begin
			run_st = STAT_OVF;
			return;
		end
		move_pc(w, h);
	endfunction

	function automatic result_t interpret(item_t it);
		result_t r;
		r = '0;
		case (it.action)
			ACT_LOAD: begin
				cells[it.cell_row*MAX_COLS + it.cell_col] = it.cell_value;
				cell_set[it.cell_row*MAX_COLS + it.cell_col] = 1;
			end
			ACT_STEP: if (run_st == STAT_RUN) run_cell(it, r);
			ACT_RESTART: begin
				vdepth = 0;
				pcc = 0;
				pcr = 0;
				hdg = HD_RIGHT;
				str_mode = 0;
				run_st = STAT_RUN;
			end
			default: ;
		endcase
		r.status = run_st;
		return r;
	endfunction

	function automatic item_t mk(logic [1:0] act, int col, int row, logic [31:0] val,
			logic [1:0] rdir, logic [7:0] ich);
		item_t it;
		it.action = act;
		it.cell_col = col[6:0];
		it.cell_row = row[4:0];
		it.cell_value = val;
		it.random_dir = rdir;
		it.input_char = ich;
		return it;
	endfunction

	function automatic logic [31:0] rand_op();
		logic [31:0] ops [29];
		ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NOT, OP_GT, OP_COMMA, OP_DOT,
			OP_END, OP_RIGHT, OP_DOWN, OP_LEFT, OP_UP, OP_RAND, OP_HBR, OP_VBR,
			OP_BRIDGE, OP_DUP, OP_SWAP, OP_DROP, OP_GET, OP_PUT, OP_INNUM, OP_INCHR,
			OP_QUOTE, 32'h3D, 32'h7B, 32'h7D};
		case ($urandom_range(0, 19))
			0: return $urandom();
			1, 2, 3, 4, 5, 6: return DIGIT_LO + $urandom_range(0, 9);
			default: return ops[$urandom_range(0, 28)];
		endcase
	endfunction

	function automatic item_t rand_item(logic [1:0] act);
		return mk(act, $urandom_range(0, act_w() - 1), $urandom_range(0, act_h() - 1),
			rand_op(), $urandom_range(0, 3), $urandom_range(0, 255));
	endfunction

	task automatic send(item_t it, bit chk = 0, result_t res = '0);
		result_t p;
		int gap;
		p = interpret(it);
		pending_q.push_back(chk ? res : p);
		gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	// load whatever cell the next step would read, so nothing unwritten is ever fetched
	task automatic prime_step();
		int unsigned w, h, c, r, t1, t2;
		w = act_w();
		h = act_h();
		if (run_st != STAT_RUN) return;
		c = pcc % w;
		r = pcr % h;
		if (!cell_set[r*MAX_COLS + c])
			send(mk(ACT_LOAD, c, r, rand_op(), 0, 0));
		if (!str_mode && cells[r*MAX_COLS + c] == OP_GET) begin
			t1 = (vdepth > 0) ? vstack[vdepth-1] : 0;
			t2 = (vdepth > 1) ? vstack[vdepth-2] : 0;
			if (t1 < h && t2 < w && !cell_set[t1*MAX_COLS + t2])
				send(mk(ACT_LOAD, t2, t1, rand_op(), 0, 0));
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic reg_write(int idx, logic [31:0] v);
		item_valid <= 1'b0;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 3'(4 * idx);
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_WIDTH) gw = v[7:0];
		else gh = v[5:0];
	endtask

	// result side: random stall bursts, check against the oldest pending result
	always @(posedge clk) begin
		result_t e;
		if (result_valid && result_ready) begin
			if (pending_q.size() == 0) begin
				errs++;
				if (errs <= 10) $display("unexpected result %p", result);
			end else begin
				e = pending_q.pop_front();
				if (result.out_kind !== e.out_kind || result.out_value !== e.out_value ||
						result.status !== e.status || result.used_input !== e.used_input) begin
					errs++;
					if (errs <= 10) $display("mismatch: expected %p got %p", e, result);
				end
			end
		end
		if (calm) begin
			result_ready <= 1'b1;
		end else if (stall > 0) begin
			stall--;
			result_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall = $urandom_range(0, 12);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	initial begin
		#20_000_000;
		$display("[befunge_playfield_core] ERROR");
		$finish;
	end

	initial begin
		dir_row_t    dtab [$];
		result_t     idle_r;
		int          ws [8];
		int          hs [8];
		logic [1:0]  a;
		for (int i = 0; i < MAX_ROWS*MAX_COLS; i++) cell_set[i] = 0;
		idle_r = '{KIND_NONE, 32'sd0, STAT_RUN, 1'b0};
		// string push of the most negative value, divided by -1, then modulo by zero,
		// empty-stack pops and a put far out of the grid
		dtab = '{
			'{mk(ACT_LOAD, 0, 0, OP_DOT, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 1, 0, OP_QUOTE, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 2, 0, 32'h8000_0000, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 3, 0, OP_QUOTE, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 4, 0, OP_INCHR, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 5, 0, OP_DIV, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 6, 0, OP_DOT, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 7, 0, DIGIT_LO, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 8, 0, OP_MOD, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 9, 0, OP_INNUM, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 10, 0, OP_PUT, 0, 0), 1, idle_r},
			'{mk(ACT_LOAD, 127, 31, 32'h7FFF_FFFF, 0, 0), 1, idle_r},
			'{mk(ACT_STEP, 0, 0, 0, 0, 0), 1, '{KIND_NUM, 32'sd0, STAT_RUN, 1'b0}},
			'{mk(ACT_STEP, 0, 0, 0, 0, 0), 0, '0},
			'{mk(ACT_STEP, 0, 0, 0, 0, 0), 0, '0},
			'{mk(ACT_STEP, 0, 0, 0, 0, 0), 0, '0},
			'{mk(ACT_STEP, 0, 0, 0, 0, 8'hFF), 0, '0},
			'{mk(ACT_STEP, 0, 0, 0, 0, 0), 0, '0},
			'{mk(ACT_STEP, 0, 0, 0, 0, 0), 1,
				'{KIND_NUM, 32'sh8000_0000, STAT_RUN, 1'b0}},
			'{mk(ACT_STEP, 0, 0, 0, 0, 0), 0, '0},
			'{mk(ACT_STEP, 0, 0, 0, 0, 0), 0, '0},
			'{mk(ACT_STEP, 0, 0, 0, 0, 8'h2F), 0, '0},
			'{mk(ACT_STEP, 0, 0, 0, 0, 0), 1, '{KIND_NONE, 32'sd0, STAT_PUT, 1'b0}},
			'{mk(ACT_STEP, 0, 0, 0, 0, 0), 1, '{KIND_NONE, 32'sd0, STAT_PUT, 1'b0}},
			'{mk(2'd3, 0, 0, 0, 0, 0), 1, '{KIND_NONE, 32'sd0, STAT_PUT, 1'b0}},
			'{mk(ACT_RESTART, 0, 0, 0, 0, 0), 1, idle_r}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dtab[i]) send(dtab[i].it, dtab[i].chk, dtab[i].res);
		drain();

		// fill the stack from a one-cell grid until it overflows
		reg_write(REG_WIDTH, 1);
		reg_write(REG_HEIGHT, 1);
		send(mk(ACT_LOAD, 0, 0, DIGIT_LO + 7, 0, 0));
		send(mk(ACT_RESTART, 0, 0, 0, 0, 0));
		for (int i = 0; i <= STACK_DEPTH; i++) send(rand_item(ACT_STEP));
		send(rand_item(ACT_STEP));
		send(mk(ACT_RESTART, 0, 0, 0, 0, 0));
		drain();

		ws = '{128, 0, 255, 5, 13, 1, 80, 3};
		hs = '{32, 0, 63, 3, 1, 9, 25, 4};
		for (int ph = 0; ph < 8; ph++) begin
			reg_write(REG_WIDTH, ws[ph]);
			reg_write(REG_HEIGHT, hs[ph]);
			calm = (ph == 7);
			send(mk(ACT_RESTART, 0, 0, 0, 0, 0));
			for (int n = 0; n < 20; n++) begin
				if (run_st != STAT_RUN && $urandom_range(0, 2) != 0) begin
					send(mk(ACT_RESTART, 0, 0, 0, 0, 0));
				end else begin
					case ($urandom_range(0, 19))
						0, 1, 2: send(rand_item(ACT_LOAD));
						3: send(mk(ACT_LOAD, $urandom_range(0, 127), $urandom_range(0, 31),
							$urandom(), 0, 0));
						4: begin
							a = ($urandom_range(0, 1) == 0) ? ACT_RESTART : 2'd3;
							send(mk(a, 0, 0, $urandom(), 0, 0));
						end
						default: begin
							prime_step();
							send(rand_item(ACT_STEP));
						end
					endcase
				end
			end
			drain();
		end
		item_valid <= 1'b0;
		if (errs == 0)
			$display("[befunge_playfield_core] OK");
		else
			$display("[befunge_playfield_core] ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/bpf_pkg.sv
hw/rtl/bpf_ram.sv
hw/rtl/befunge_playfield_core.sv
tb/tb.sv
